[hdl/tlln_pkg.sv]
// tlln_pkg: shared types, constants and the microprogram of the two-layer linear network.
// No dependencies; used by tlln_seq, tlln_dp and two_layer_linear_network.
`default_nettype none

package tlln_pkg;

  // Fixed field widths and network shape.
  localparam int DW        = 16;  // data width, Q8.8
  localparam int WW        = 16;  // weight width, Q4.12
  localparam int WFRAC     = 12;  // weight fraction bits
  localparam int IN_CNT    = 6;   // network inputs
  localparam int OUT_CNT   = 2;   // network outputs
  localparam int HIDDEN_NODES_DEF = 6;
  localparam int HIDDEN_MAX = 16;
  // Accumulator holds the sum of up to HIDDEN_MAX products exactly.
  localparam int ACC_W     = DW + WW + $clog2(HIDDEN_MAX) + 1;
  localparam int QW        = ACC_W - WFRAC;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Layer select.
  localparam logic LAYER_HID = 1'b0;
  localparam logic LAYER_OUT = 1'b1;

  // Microprogram step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_HMAC   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HDRAIN = 3'd2;
  localparam logic [STEP_W-1:0] STEP_OMAC   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FIN    = 3'd4;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_EVAL,
    COND_LOOP_END,
    COND_DRAINED,
    COND_DRAINED_FREE
  } cond_t;

  // One control word: jump to jmp when cond holds, else repeat the step.
  typedef struct packed {
    logic              issue;
    logic              layer;
    logic              clr;
    cond_t             cond;
    logic [STEP_W-1:0] jmp;
  } uword_t;

  typedef struct packed {
    logic                 operation;
    logic [5:0]           weight_index;
    logic signed [WW-1:0] weight_value;
    logic signed [DW-1:0] x_error;
    logic signed [DW-1:0] y_error;
    logic signed [DW-1:0] angle_error;
    logic signed [DW-1:0] vx_error;
    logic signed [DW-1:0] vy_error;
    logic signed [DW-1:0] rate_error;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] jet_force;
    logic signed [DW-1:0] correction_force;
  } out_item_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic issue;
    logic layer;
    logic first;
    logic last;
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic drained;
    logic out_busy;
  } sts_t;

  function automatic uword_t ucode(logic [STEP_W-1:0] pc);
    uword_t w;
    unique case (pc)
      STEP_IDLE:   w = '{issue: 1'b0, layer: LAYER_HID, clr: 1'b1,
                         cond: COND_EVAL,         jmp: STEP_HMAC};
      STEP_HMAC:   w = '{issue: 1'b1, layer: LAYER_HID, clr: 1'b0,
                         cond: COND_LOOP_END,     jmp: STEP_HDRAIN};
      STEP_HDRAIN: w = '{issue: 1'b0, layer: LAYER_OUT, clr: 1'b1,
                         cond: COND_DRAINED_FREE, jmp: STEP_OMAC};
      STEP_OMAC:   w = '{issue: 1'b1, layer: LAYER_OUT, clr: 1'b0,
                         cond: COND_LOOP_END,     jmp: STEP_FIN};
      STEP_FIN:    w = '{issue: 1'b0, layer: LAYER_OUT, clr: 1'b1,
                         cond: COND_DRAINED,      jmp: STEP_IDLE};
      default:     w = '{issue: 1'b0, layer: LAYER_HID, clr: 1'b1,
                         cond: COND_ALWAYS,       jmp: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Round Q17.20 to Q8.8 (add half, floor shift) and saturate.
  function automatic logic signed [DW-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic signed [QW-1:0]    q;
    logic signed [QW-1:0]    qmax;
    logic signed [QW-1:0]    qmin;
    logic signed [DW-1:0]    res;
    qmax = QW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    qmin = ~qmax;
    r = acc + (ACC_W'(1) << (WFRAC - 1));
    q = r[ACC_W-1:WFRAC];
    if (q > qmax) begin
      res = DW'(qmax);
    end else if (q < qmin) begin
      res = DW'(qmin);
    end else begin
      res = DW'(q);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/tlln_seq.sv]
// tlln_seq: microcoded sequencer - step counter, control ROM, loop counters.
// Depends on tlln_pkg (ucode, ctl_t, sts_t).
`default_nettype none

module tlln_seq #(
  parameter int  HIDDEN_NODES = tlln_pkg::HIDDEN_NODES_DEF,
  localparam int TW = $clog2(tlln_pkg::IN_CNT > HIDDEN_NODES ?
                             tlln_pkg::IN_CNT : HIDDEN_NODES),
  localparam int NW = $clog2(HIDDEN_NODES > tlln_pkg::OUT_CNT ?
                             HIDDEN_NODES : tlln_pkg::OUT_CNT)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  eval_go,
  input  wire tlln_pkg::sts_t        sts,
  output tlln_pkg::ctl_t             ctl,
  output logic [TW-1:0]              term,
  output logic [NW-1:0]              node,
  output logic                       idle
);

  logic [tlln_pkg::STEP_W-1:0] pc_r, pc_nxt;
  logic [TW-1:0]               term_r, term_nxt;
  logic [NW-1:0]               node_r, node_nxt;
  tlln_pkg::uword_t            uw;
  logic [TW-1:0]               term_last;
  logic [NW-1:0]               node_last;
  logic                        loop_end;
  logic                        met;

  assign uw = tlln_pkg::ucode(pc_r);

  always_comb begin
    if (uw.layer == tlln_pkg::LAYER_OUT) begin
      term_last = TW'(HIDDEN_NODES - 1);
      node_last = NW'(tlln_pkg::OUT_CNT - 1);
    end else begin
      term_last = TW'(tlln_pkg::IN_CNT - 1);
      node_last = NW'(HIDDEN_NODES - 1);
    end
  end

  assign loop_end = (term_r == term_last) && (node_r == node_last);

  always_comb begin
    unique case (uw.cond)
      tlln_pkg::COND_ALWAYS:       met = 1'b1;
      tlln_pkg::COND_EVAL:         met = eval_go;
      tlln_pkg::COND_LOOP_END:     met = loop_end;
      tlln_pkg::COND_DRAINED:      met = sts.drained;
      tlln_pkg::COND_DRAINED_FREE: met = sts.drained && !sts.out_busy;
      default:                     met = 1'b1;
    endcase
    pc_nxt   = met ? uw.jmp : pc_r;
    term_nxt = term_r;
    node_nxt = node_r;
    if (uw.clr) begin
      term_nxt = '0;
      node_nxt = '0;
    end else if (uw.issue) begin
      if (term_r == term_last) begin
        term_nxt = '0;
        node_nxt = node_r + NW'(1);
      end else begin
        term_nxt = term_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= tlln_pkg::STEP_IDLE;
      term_r <= '0;
      node_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      term_r <= term_nxt;
      node_r <= node_nxt;
    end
  end

  assign ctl.issue = uw.issue;
  assign ctl.layer = uw.layer;
  assign ctl.first = (term_r == '0);
  assign ctl.last  = (term_r == term_last);
  assign term      = term_r;
  assign node      = node_r;
  assign idle      = (pc_r == tlln_pkg::STEP_IDLE);

endmodule

`default_nettype wire

[hdl/tlln_dp.sv]
// tlln_dp: weight memory, input and hidden registers, 3-stage MAC pipe, result register.
// Depends on tlln_pkg (item types, ctl_t, sts_t, round_sat).
`default_nettype none

module tlln_dp #(
  parameter int  HIDDEN_NODES = tlln_pkg::HIDDEN_NODES_DEF,
  localparam int TW = $clog2(tlln_pkg::IN_CNT > HIDDEN_NODES ?
                             tlln_pkg::IN_CNT : HIDDEN_NODES),
  localparam int NW = $clog2(HIDDEN_NODES > tlln_pkg::OUT_CNT ?
                             HIDDEN_NODES : tlln_pkg::OUT_CNT)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_acc,
  input  wire tlln_pkg::in_item_t    in_item,
  input  wire tlln_pkg::ctl_t        ctl,
  input  wire logic [TW-1:0]         term,
  input  wire logic [NW-1:0]         node,
  output tlln_pkg::sts_t             sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tlln_pkg::out_item_t        out_item
);

  localparam int DW    = tlln_pkg::DW;
  localparam int WW    = tlln_pkg::WW;
  localparam int ACC_W = tlln_pkg::ACC_W;
  localparam int DEPTH    = (tlln_pkg::IN_CNT + tlln_pkg::OUT_CNT) * HIDDEN_NODES;
  localparam int OUT_BASE = tlln_pkg::IN_CNT * HIDDEN_NODES;
  localparam int AW       = $clog2(DEPTH);
  localparam int XIW      = $clog2(tlln_pkg::IN_CNT);
  localparam int HIW      = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;

  // Weight store; valid bits make unwritten entries read as zero.
  logic [WW-1:0]            wmem [DEPTH];
  logic [DEPTH-1:0]         wvld_r;
  logic                     wr_en;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;

  logic signed [DW-1:0]     x_r   [tlln_pkg::IN_CNT];
  logic signed [DW-1:0]     hid_r [HIDDEN_NODES];

  // Stage 1: read data and operand.
  logic                     v1_r, first1_r, last1_r, layer1_r;
  logic [NW-1:0]            node1_r;
  logic signed [DW-1:0]     opnd1_r;
  logic [WW-1:0]            rdata_r;
  logic                     rvld_r;
  logic signed [WW-1:0]     wgt;
  // Stage 2: product.
  logic                     v2_r, first2_r, last2_r, layer2_r;
  logic [NW-1:0]            node2_r;
  logic signed [DW+WW-1:0]  prod_r;
  // Stage 3: accumulator, sink pending when v3_r.
  logic                     v3_r, layer3_r;
  logic [NW-1:0]            node3_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DW-1:0]     rs;

  logic                     out_valid_r;
  logic signed [DW-1:0]     jet_r, corr_r;

  assign wr_en = in_acc && (in_item.operation == tlln_pkg::OP_WRITE) &&
                 (int'(in_item.weight_index) < DEPTH);
  assign waddr = AW'(in_item.weight_index);

  always_comb begin
    if (ctl.layer == tlln_pkg::LAYER_OUT) begin
      raddr = AW'(OUT_BASE + int'(node) * HIDDEN_NODES + int'(term));
    end else begin
      raddr = AW'(int'(node) * tlln_pkg::IN_CNT + int'(term));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[waddr] <= in_item.weight_value;
    end
    rdata_r <= wmem[raddr];
    rvld_r  <= wvld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
    end else if (wr_en) begin
      wvld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_item.operation == tlln_pkg::OP_EVAL)) begin
      x_r[0] <= in_item.x_error;
      x_r[1] <= in_item.y_error;
      x_r[2] <= in_item.angle_error;
      x_r[3] <= in_item.vx_error;
      x_r[4] <= in_item.vy_error;
      x_r[5] <= in_item.rate_error;
    end
  end

  // Pipe valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r && last2_r;
    end
  end

  assign wgt = rvld_r ? signed'(rdata_r) : '0;

  always_ff @(posedge clk) begin
    first1_r <= ctl.first;
    last1_r  <= ctl.last;
    layer1_r <= ctl.layer;
    node1_r  <= node;
    opnd1_r  <= (ctl.layer == tlln_pkg::LAYER_OUT) ? hid_r[term[HIW-1:0]]
                                                   : x_r[term[XIW-1:0]];
    first2_r <= first1_r;
    last2_r  <= last1_r;
    layer2_r <= layer1_r;
    node2_r  <= node1_r;
    prod_r   <= opnd1_r * wgt;
    layer3_r <= layer2_r;
    node3_r  <= node2_r;
    if (v2_r) begin
      acc_r <= first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  assign rs = tlln_pkg::round_sat(acc_r);

  always_ff @(posedge clk) begin
    if (v3_r) begin
      if (layer3_r == tlln_pkg::LAYER_HID) begin
        hid_r[node3_r[HIW-1:0]] <= rs;
      end else if (node3_r[0] == 1'b0) begin
        jet_r <= rs;
      end else begin
        corr_r <= rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v3_r && (layer3_r == tlln_pkg::LAYER_OUT) && node3_r[0]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.drained  = !v1_r && !v2_r && !v3_r;
  assign sts.out_busy = out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_item.jet_force        = jet_r;
  assign out_item.correction_force = corr_r;

endmodule

`default_nettype wire

[hdl/two_layer_linear_network.sv]
// two_layer_linear_network: top level of the 6-input, N-hidden, 2-output linear network.
// Depends on tlln_pkg, tlln_seq and tlln_dp.
`default_nettype none

// Channel  Ports                          Moves
// -------  -----------------------------  ------------------------------------
// in       in_valid, in_ready, in_data    weight write or evaluate request
// out      out_valid, out_ready, out_data jet and correction force, one per eval
//
// A weight write is only the transfer itself. An evaluate runs through the
// single shared MAC in order: the 6*N hidden terms, a pipe drain, the 2*N output
// terms and a final drain.
// in_ready is high only while the sequencer sits in its idle step.
// A result still waiting on out_ready holds the next evaluate ahead of its output layer.
// Reset clears the sequencer, pipe flags, weight valid bits (the store reads zero) and out_valid.

module two_layer_linear_network #(
  parameter int HIDDEN_NODES = tlln_pkg::HIDDEN_NODES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlln_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlln_pkg::out_item_t      out_data
);

  localparam int TW = $clog2(tlln_pkg::IN_CNT > HIDDEN_NODES ?
                             tlln_pkg::IN_CNT : HIDDEN_NODES);
  localparam int NW = $clog2(HIDDEN_NODES > tlln_pkg::OUT_CNT ?
                             HIDDEN_NODES : tlln_pkg::OUT_CNT);

  logic            in_acc;
  logic            eval_go;
  logic            idle;
  tlln_pkg::ctl_t  ctl;
  tlln_pkg::sts_t  sts;
  logic [TW-1:0]   term;
  logic [NW-1:0]   node;

  // Input transfer; a write lands in the store on this same edge.
  assign in_ready = idle;
  assign in_acc   = in_valid && in_ready;
  assign eval_go  = in_acc && (in_data.operation == tlln_pkg::OP_EVAL);

  tlln_seq #(
    .HIDDEN_NODES(HIDDEN_NODES)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .eval_go (eval_go),
    .sts     (sts),
    .ctl     (ctl),
    .term    (term),
    .node    (node),
    .idle    (idle)
  );

  tlln_dp #(
    .HIDDEN_NODES(HIDDEN_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_data),
    .ctl       (ctl),
    .term      (term),
    .node      (node),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire

[tb/two_layer_linear_network_tb.sv]
// Self-checking testbench for two_layer_linear_network: weight writes and evaluations
// go in over valid/ready, and each force pair coming out is checked against a local model.
// Depends on tlln_pkg and the two_layer_linear_network RTL.
`timescale 1ns / 100ps

module two_layer_linear_network_tb;

  // Network shape, matching the default build of the block.
  localparam int HIDDEN      = tlln_pkg::HIDDEN_NODES_DEF;
  localparam int OUT_BASE    = HIDDEN * tlln_pkg::IN_CNT;
  localparam int STORE_DEPTH = OUT_BASE + tlln_pkg::OUT_CNT * HIDDEN;

  // Value classes for random fields.
  localparam int CLS_FULL = 0;  // any 16-bit value
  localparam int CLS_NEAR = 1;  // small magnitude, mostly unsaturated sums
  localparam int CLS_EDGE = 2;  // extremes, zero and +-1 lsb

  localparam int HOLD_CYCLES  = 400;  // long out_ready hold-off
  localparam int DRAIN_CYCLES = 80;   // above the time of one evaluate
  localparam int MAX_REPORTS  = 10;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  tlln_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tlln_pkg::out_item_t out_data;

  two_layer_linear_network dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Local copy of the weight store; cleared like the block's at reset.
  logic signed [tlln_pkg::WW-1:0] weight_model [STORE_DEPTH];

  tlln_pkg::in_item_t  pending_q[$];        // items waiting to be driven
  tlln_pkg::out_item_t expected_forces[$];  // force pairs owed by the block

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_cnt  = 0;  // bumped by the main sequence to ask for a hold-off
  int hold_taken    = 0;
  int hold_left     = 0;
  logic in_took = 1'b0;   // input transfer seen at the last rising edge

  int writes_taken   = 0;
  int evals_taken    = 0;
  int pairs_checked  = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sum of Q12.20 products to Q8.8: add half an lsb, floor shift, clamp to 16 bits.
  function automatic longint to_q88(longint acc);
    longint q;
    q = (acc + (longint'(1) << (tlln_pkg::WFRAC - 1))) >>> tlln_pkg::WFRAC;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Both layers, exact products and sums; each layer rounded and clamped.
  function automatic tlln_pkg::out_item_t network_forces(tlln_pkg::in_item_t req);
    longint              xs  [tlln_pkg::IN_CNT];
    longint              hid [HIDDEN];
    longint              acc;
    tlln_pkg::out_item_t res;
    xs[0] = req.x_error;
    xs[1] = req.y_error;
    xs[2] = req.angle_error;
    xs[3] = req.vx_error;
    xs[4] = req.vy_error;
    xs[5] = req.rate_error;
    for (int n = 0; n < HIDDEN; n++) begin
      acc = 0;
      for (int i = 0; i < tlln_pkg::IN_CNT; i++) begin
        acc += xs[i] * longint'(weight_model[n * tlln_pkg::IN_CNT + i]);
      end
      hid[n] = to_q88(acc);
    end
    // Output 0 is the jet force, output 1 the correction force, each on its own row.
    acc = 0;
    for (int n = 0; n < HIDDEN; n++) acc += hid[n] * longint'(weight_model[OUT_BASE + n]);
    res.jet_force = 16'(to_q88(acc));
    acc = 0;
    for (int n = 0; n < HIDDEN; n++) begin
      acc += hid[n] * longint'(weight_model[OUT_BASE + HIDDEN + n]);
    end
    res.correction_force = 16'(to_q88(acc));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Fields the operation ignores carry random bits.
  // ---------------------------------------------------------------------------

  function automatic tlln_pkg::in_item_t random_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tlln_pkg::in_item_t)-1:0];
  endfunction

  function automatic tlln_pkg::in_item_t make_write(int idx, logic [15:0] val);
    tlln_pkg::in_item_t item;
    item = random_item();
    item.operation    = tlln_pkg::OP_WRITE;
    item.weight_index = idx[5:0];
    item.weight_value = val;
    return item;
  endfunction

  function automatic tlln_pkg::in_item_t make_eval(logic [15:0] e0, logic [15:0] e1,
                                                   logic [15:0] e2, logic [15:0] e3,
                                                   logic [15:0] e4, logic [15:0] e5);
    tlln_pkg::in_item_t item;
    item = random_item();
    item.operation   = tlln_pkg::OP_EVAL;
    item.x_error     = e0;
    item.y_error     = e1;
    item.angle_error = e2;
    item.vx_error    = e3;
    item.vy_error    = e4;
    item.rate_error  = e5;
    return item;
  endfunction

  function automatic logic [15:0] rand_val(int cls, int span);
    logic [15:0] v;
    case (cls)
      CLS_FULL: v = 16'($urandom);
      CLS_NEAR: v = 16'($urandom_range(2 * span) - span);
      default: begin
        case ($urandom_range(4))
          0:       v = 16'h7fff;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          3:       v = 16'h0001;
          default: v = 16'hffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int pick_class();
    int r;
    r = $urandom_range(9);
    if (r < 4) return CLS_NEAR;
    if (r < 8) return CLS_FULL;
    return CLS_EDGE;
  endfunction

  // Rounds of weight loading followed by a burst of evaluations. Writes past the
  // store are dropped by the block and do not count toward the target.
  task automatic fill_phase(int target);
    int added;
    int wcls;
    int ecls;
    int n;
    added = 0;
    while (added < target) begin
      wcls = pick_class();
      if ($urandom_range(3) == 0) begin
        for (int k = 0; k < STORE_DEPTH; k++) pending_q.push_back(make_write(k, rand_val(wcls, 4096)));
        added += STORE_DEPTH;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          pending_q.push_back(make_write($urandom_range(STORE_DEPTH - 1), rand_val(wcls, 4096)));
        end
        added += n;
      end
      if ($urandom_range(7) == 0) begin
        pending_q.push_back(make_write($urandom_range(63, STORE_DEPTH), 16'($urandom)));
      end
      ecls = pick_class();
      n = $urandom_range(1, 12);
      repeat (n) begin
        pending_q.push_back(make_eval(rand_val(ecls, 1024), rand_val(ecls, 1024),
                                      rand_val(ecls, 1024), rand_val(ecls, 1024),
                                      rand_val(ecls, 1024), rand_val(ecls, 1024)));
      end
      added += n;
    end
  endtask

  // Sender pause: nothing queued, nothing offered, every result back.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_forces.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new payload at the falling edge once the previous transfer is done.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked. The hold-off fills
  // the block, so the next evaluate parks and in_ready stays low.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_taken != hold_req_cnt) begin
      hold_taken = hold_taken + 1;
      hold_left  = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tlln_pkg::out_item_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        if (in_data.operation == tlln_pkg::OP_EVAL) begin
          expected_forces.push_back(network_forces(in_data));
          evals_taken++;
        end else begin
          // Indices past the store are dropped.
          if (in_data.weight_index < STORE_DEPTH) begin
            weight_model[in_data.weight_index] = in_data.weight_value;
          end
          writes_taken++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: force pair with none expected: jet %0d corr %0d",
                     $realtime, out_data.jet_force, out_data.correction_force);
          end
          mismatch_count++;
        end else begin
          want = expected_forces.pop_front();
          if (out_data.jet_force !== want.jet_force ||
              out_data.correction_force !== want.correction_force) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("%0t: pair %0d: jet exp %0d got %0d, corr exp %0d got %0d",
                       $realtime, pairs_checked, want.jet_force, out_data.jet_force,
                       want.correction_force, out_data.correction_force);
            end
            mismatch_count++;
          end
          pairs_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < STORE_DEPTH; k++) weight_model[k] = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Phase 0: sender idles 24%, receiver 47%.
    send_idle_pct = 24;
    recv_idle_pct = 47;

    // Directed: cleared store gives zero forces.
    pending_q.push_back(make_eval(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom)));
    // Extreme weights; the correction row gets its own, opposite weight.
    pending_q.push_back(make_write(0, 16'h7fff));
    pending_q.push_back(make_write(OUT_BASE, 16'h7fff));
    pending_q.push_back(make_write(OUT_BASE + HIDDEN, 16'h8000));
    // Writes past the store must leave it untouched.
    pending_q.push_back(make_write(STORE_DEPTH, 16'h1234));
    pending_q.push_back(make_write(63, 16'hffff));
    // Full-scale inputs: both layers saturate, one force each way; then all-zero inputs.
    pending_q.push_back(make_eval(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    pending_q.push_back(make_eval(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(make_eval(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Unit and half weights to land rounding right on the half-lsb boundary.
    pending_q.push_back(make_write(1, 16'h1000));
    pending_q.push_back(make_write(tlln_pkg::IN_CNT + 1, 16'h1000));
    pending_q.push_back(make_write(OUT_BASE + 1, 16'h0800));
    pending_q.push_back(make_write(OUT_BASE + HIDDEN + 1, 16'hf800));
    pending_q.push_back(make_eval(16'h0100, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_q.push_back(make_eval(16'hff00, 16'hfffd, 16'h0001, 16'hffff, 16'h0000, 16'h0000));
    pending_q.push_back(make_eval(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Most negative weights at the far end of the store and on hidden node 0's last input term.
    pending_q.push_back(make_write(STORE_DEPTH - 1, 16'h8000));
    pending_q.push_back(make_write(tlln_pkg::IN_CNT - 1, 16'h8000));
    pending_q.push_back(make_eval(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'h8000));

    fill_phase(580);
    wait_drained();

    // Phase 1: roles swapped.
    send_idle_pct = 47;
    recv_idle_pct = 24;
    fill_phase(650);
    wait_drained();

    // Phase 2: no random idling, but a long receiver hold-off right away
    // while the sender keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_phase(650);
    hold_req_cnt++;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d weight writes and %0d evaluations; checked %0d force pairs.",
             writes_taken, evals_taken, pairs_checked);
    $display("Idle mixes 24/47, 47/24 and none, one %0d-cycle output hold-off; %0d bad.",
             HOLD_CYCLES, mismatch_count + expected_forces.size());
    if (mismatch_count == 0 && expected_forces.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
